// ----- rtl/lsms_pkg.sv -----
// Shared types and constants for the latching starter motor sequencer.
// Holds word layouts, register indexes, event kinds, result and state codes.
// No dependencies.
`default_nettype none

package lsms_pkg;

	// Timer width default and comparison width
	localparam int TIMER_BITS_DEF = 32;
	localparam int CMP_W          = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_START   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TMO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_WELL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_BORE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_GRACE  = 3'd7;

	// Register reset values
	localparam logic [23:0] MIN_OFF_RST    = 24'd0;
	localparam logic [23:0] PRE_START_RST  = 24'd10000;
	localparam logic [23:0] QUIET_TMO_RST  = 24'd30000;
	localparam logic [23:0] SETTLE_RST     = 24'd500;
	localparam logic [15:0] PULSE_RST      = 16'd500;
	localparam logic [15:0] AMP_WELL_RST   = 16'd50;
	localparam logic [15:0] AMP_BORE_RST   = 16'd50;
	localparam logic [23:0] BOOT_GRACE_RST = 24'd5000;

	typedef struct packed {
		logic [23:0] min_off_ms;
		logic [23:0] pre_start_ms;
		logic [23:0] quiet_tmo_ms;
		logic [23:0] settle_ms;
		logic [15:0] pulse_ms;
		logic [15:0] amp_low_well;
		logic [15:0] amp_low_bore;
		logic [23:0] boot_grace_ms;
	} cfg_t;

	// Event kinds
	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_START    = 3'd1;
	localparam logic [2:0] KIND_STOP     = 3'd2;
	localparam logic [2:0] KIND_ENABLE   = 3'd3;
	localparam logic [2:0] KIND_LOCKOUT  = 3'd4;
	localparam logic [2:0] KIND_CLEAR    = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic        motor;
		logic [7:0]  reason;
		logic        switch_on;
		logic [15:0] amps;
		logic        current_armed;
		logic [3:0]  start_gate_trip;
		logic        routing_valid;
		logic [3:0]  prot_trip;
	} item_t;

	// Start request results
	localparam logic [3:0] RES_ACCEPTED = 4'd0;
	localparam logic [3:0] RES_DISABLED = 4'd1;
	localparam logic [3:0] RES_LOCKOUT  = 4'd2;
	localparam logic [3:0] RES_WELDED   = 4'd3;
	localparam logic [3:0] RES_FAULT    = 4'd4;
	localparam logic [3:0] RES_BUSY     = 4'd5;
	localparam logic [3:0] RES_SHORT    = 4'd6;
	localparam logic [3:0] RES_UNCAL    = 4'd7;
	localparam logic [3:0] RES_GATE     = 4'd8;
	localparam logic [3:0] RES_ROUTING  = 4'd9;

	// Drive state codes as reported on drive_state
	localparam logic [3:0] DRV_DISABLED = 4'd0;
	localparam logic [3:0] DRV_IDLE     = 4'd1;
	localparam logic [3:0] DRV_LOCKED   = 4'd2;
	localparam logic [3:0] DRV_PRE      = 4'd3;
	localparam logic [3:0] DRV_QUIET    = 4'd4;
	localparam logic [3:0] DRV_CHANGE   = 4'd5;
	localparam logic [3:0] DRV_SPULSE   = 4'd6;
	localparam logic [3:0] DRV_SCONF    = 4'd7;
	localparam logic [3:0] DRV_RUN      = 4'd8;
	localparam logic [3:0] DRV_XPULSE   = 4'd9;
	localparam logic [3:0] DRV_XCONF    = 4'd10;
	localparam logic [3:0] DRV_FAULT    = 4'd11;
	localparam logic [3:0] DRV_WELDED   = 4'd12;

	// Buzzer modes
	localparam logic [1:0] BUZ_SILENT    = 2'd0;
	localparam logic [1:0] BUZ_COUNTDOWN = 2'd1;
	localparam logic [1:0] BUZ_ALARM     = 2'd2;

	// Relay bit positions
	localparam int RLY_CO    = 0;
	localparam int RLY_START = 1;
	localparam int RLY_STOP  = 2;

	// Internal stop reasons and trip codes
	localparam logic [7:0] RSN_LOCKOUT    = 8'd253;
	localparam logic [7:0] RSN_PROTECTION = 8'd254;
	localparam logic [7:0] RSN_POWER_CUT  = 8'd255;
	localparam logic [3:0] TRIP_NONE        = 4'd0;
	localparam logic [3:0] TRIP_STOP_FAILED = 4'd15;

	typedef struct packed {
		logic [3:0]  start_result;
		logic [3:0]  drive_state;
		logic        changeover_relay;
		logic        start_relay;
		logic        stop_relay;
		logic [1:0]  buzzer_mode;
		logic [3:0]  last_trip;
		logic        event_valid;
		logic        event_on;
		logic [7:0]  event_reason;
		logic [31:0] running_ms;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/lsms_core.sv -----
// Sequencer state machine, timers and result register.
// Updates all state for one event word per fire and registers the result word.
// Depends on lsms_pkg.
`default_nettype none

module lsms_core #(
	parameter int TIMER_BITS = lsms_pkg::TIMER_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire lsms_pkg::item_t item,
	input  wire lsms_pkg::cfg_t  cfg,
	output lsms_pkg::res_t       res
);
	import lsms_pkg::*;

	typedef enum logic [3:0] {
		ST_DISABLED = DRV_DISABLED,
		ST_IDLE     = DRV_IDLE,
		ST_LOCKED   = DRV_LOCKED,
		ST_PRE      = DRV_PRE,
		ST_QUIET    = DRV_QUIET,
		ST_CHANGE   = DRV_CHANGE,
		ST_SPULSE   = DRV_SPULSE,
		ST_SCONF    = DRV_SCONF,
		ST_RUN      = DRV_RUN,
		ST_XPULSE   = DRV_XPULSE,
		ST_XCONF    = DRV_XCONF,
		ST_FAULT    = DRV_FAULT,
		ST_WELDED   = DRV_WELDED
	} state_t;

	typedef logic [TIMER_BITS-1:0] tmr_t;

	localparam tmr_t TONE = tmr_t'(1);

	function automatic tmr_t sat_inc(input tmr_t v);
		return (&v) ? v : v + TONE;
	endfunction

	function automatic logic reached(input tmr_t t, input logic [23:0] lim);
		return CMP_W'(t) >= CMP_W'(lim);
	endfunction

	// State registers
	state_t      mode_q;
	logic        enable_q, lockout_q, sel_q, req_q, stopped_q;
	logic [7:0]  rsn_q;
	logic [3:0]  trip_q;
	logic [2:0]  relay_q;
	logic [1:0]  buz_q;
	tmr_t        tis_q, trun_q, tss_q, boot_q;
	res_t        res_q;

	// Next-state values
	state_t      md, go_st;
	logic        go_en;
	logic        en, lo, sel, req, hs, flow, evv, evon;
	logic [7:0]  rsn, evr;
	logic [3:0]  trip, sres;
	logic [2:0]  rel;
	logic [1:0]  buz;
	tmr_t        tis, trun, tss, boot;

	// Evaluate one event against the present state
	always_comb begin
		md    = mode_q;
		en    = enable_q;
		lo    = lockout_q;
		sel   = sel_q;
		req   = req_q;
		hs    = stopped_q;
		rsn   = rsn_q;
		trip  = trip_q;
		rel   = relay_q;
		buz   = buz_q;
		tis   = tis_q;
		trun  = trun_q;
		tss   = tss_q;
		boot  = boot_q;
		go_en = 1'b0;
		go_st = mode_q;
		evv   = 1'b0;
		evon  = 1'b0;
		evr   = 8'd0;
		sres  = RES_ACCEPTED;
		flow  = item.amps >= (sel_q ? cfg.amp_low_bore : cfg.amp_low_well);

		case (item.kind)
			KIND_TICK: begin
				tis  = sat_inc(tis_q);
				trun = sat_inc(trun_q);
				tss  = sat_inc(tss_q);
				boot = sat_inc(boot_q);
				if (enable_q && !(CMP_W'(boot) < CMP_W'(cfg.boot_grace_ms))) begin
					case (mode_q)
						ST_WELDED: begin
							if (buz_q == BUZ_SILENT) buz = BUZ_ALARM;
							if (!flow) begin
								buz = BUZ_SILENT;
								tss = '0;
								hs = 1'b1;
								go_en = 1'b1; go_st = ST_IDLE;
							end
						end
						ST_IDLE: begin
							if (flow) begin
								trun = '0;
								go_en = 1'b1; go_st = ST_RUN;
							end
						end
						ST_PRE: begin
							if (reached(tis, cfg.pre_start_ms)) begin
								buz = BUZ_SILENT;
								go_en = 1'b1;
								if (item.start_gate_trip != TRIP_NONE) begin
									trip = item.start_gate_trip;
									go_st = ST_FAULT;
								end else if (req_q == sel_q) begin
									rel[RLY_START] = 1'b1;
									go_st = ST_SPULSE;
								end else begin
									go_st = ST_QUIET;
								end
							end
						end
						ST_QUIET: begin
							if (!flow) begin
								sel = req_q;
								rel[RLY_CO] = req_q;
								go_en = 1'b1; go_st = ST_CHANGE;
							end else if (reached(tis, cfg.quiet_tmo_ms)) begin
								trip = TRIP_STOP_FAILED;
								go_en = 1'b1; go_st = ST_FAULT;
							end
						end
						ST_CHANGE: begin
							if (reached(tis, cfg.settle_ms)) begin
								rel[RLY_START] = 1'b1;
								go_en = 1'b1; go_st = ST_SPULSE;
							end
						end
						ST_SPULSE, ST_XPULSE: begin
							if (reached(tis, 24'(cfg.pulse_ms))) begin
								rel[RLY_START] = 1'b0;
								rel[RLY_STOP]  = 1'b0;
								go_en = 1'b1;
								go_st = (mode_q == ST_SPULSE) ? ST_SCONF : ST_XCONF;
							end
						end
						ST_SCONF: begin
							if (flow) begin
								trun = '0;
								evv = 1'b1; evon = 1'b1; evr = rsn_q;
								go_en = 1'b1; go_st = ST_RUN;
							end else if (item.prot_trip != TRIP_NONE) begin
								trip = item.prot_trip;
								go_en = 1'b1; go_st = ST_FAULT;
							end
						end
						ST_RUN: begin
							if (!flow) begin
								tss = '0;
								hs = 1'b1;
								evv = 1'b1; evr = RSN_POWER_CUT;
								go_en = 1'b1; go_st = ST_IDLE;
							end else if (item.prot_trip != TRIP_NONE) begin
								trip = item.prot_trip;
								rsn = RSN_PROTECTION;
								rel[RLY_START] = 1'b0;
								rel[RLY_STOP]  = 1'b1;
								go_en = 1'b1; go_st = ST_XPULSE;
							end
						end
						ST_XCONF: begin
							if (!flow) begin
								tss = '0;
								hs = 1'b1;
								evv = 1'b1; evr = rsn_q;
								go_en = 1'b1;
								go_st = lockout_q ? ST_LOCKED :
									((trip_q != TRIP_NONE) ? ST_FAULT : ST_IDLE);
							end else if (item.prot_trip != TRIP_NONE) begin
								trip = item.prot_trip;
								go_en = 1'b1; go_st = ST_WELDED;
							end
						end
						default: begin
						end
					endcase
				end
			end
			KIND_START: begin
				if (!enable_q) sres = RES_DISABLED;
				else if (lockout_q) sres = RES_LOCKOUT;
				else if (mode_q == ST_WELDED) sres = RES_WELDED;
				else if (mode_q == ST_FAULT) sres = RES_FAULT;
				else if (mode_q != ST_IDLE) sres = RES_BUSY;
				else if (stopped_q && (CMP_W'(tss_q) < CMP_W'(cfg.min_off_ms)))
					sres = RES_SHORT;
				else if (!item.current_armed) sres = RES_UNCAL;
				else if (item.start_gate_trip != TRIP_NONE) begin
					trip = item.start_gate_trip;
					sres = RES_GATE;
				end else if (item.motor && !item.routing_valid) sres = RES_ROUTING;
				else begin
					req = item.motor;
					rsn = item.reason;
					buz = BUZ_COUNTDOWN;
					go_en = 1'b1; go_st = ST_PRE;
				end
			end
			KIND_STOP: begin
				if (enable_q) begin
					if (mode_q == ST_PRE) begin
						buz = BUZ_SILENT;
						go_en = 1'b1; go_st = ST_IDLE;
					end else if (mode_q == ST_RUN || mode_q == ST_SCONF ||
							mode_q == ST_SPULSE) begin
						rsn = item.reason;
						rel[RLY_START] = 1'b0;
						rel[RLY_STOP]  = 1'b1;
						go_en = 1'b1; go_st = ST_XPULSE;
					end
				end
			end
			KIND_ENABLE: begin
				en = item.switch_on;
				go_en = 1'b1;
				if (!item.switch_on) begin
					rel[RLY_START] = 1'b0;
					rel[RLY_STOP]  = 1'b0;
					go_st = ST_DISABLED;
				end else begin
					go_st = lockout_q ? ST_LOCKED : ST_IDLE;
				end
			end
			KIND_LOCKOUT: begin
				lo = item.switch_on;
				if (enable_q) begin
					if (item.switch_on) begin
						if (mode_q == ST_RUN || mode_q == ST_SCONF) begin
							rsn = RSN_LOCKOUT;
							rel[RLY_START] = 1'b0;
							rel[RLY_STOP]  = 1'b1;
							go_en = 1'b1; go_st = ST_XPULSE;
						end else if (mode_q == ST_IDLE || mode_q == ST_PRE) begin
							buz = BUZ_SILENT;
							go_en = 1'b1; go_st = ST_LOCKED;
						end
					end else if (mode_q == ST_LOCKED) begin
						go_en = 1'b1; go_st = ST_IDLE;
					end
				end
			end
			KIND_CLEAR: begin
				if (mode_q == ST_FAULT) begin
					trip = TRIP_NONE;
					go_en = 1'b1;
					go_st = lockout_q ? ST_LOCKED : ST_IDLE;
				end
			end
			default: begin
			end
		endcase

		// Enter the new state and restart its timer on a real change
		if (go_en && go_st != mode_q) begin
			md  = go_st;
			tis = '0;
		end
	end

	// Hold state and the result word; advance on fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ST_IDLE;
			enable_q  <= 1'b1;
			lockout_q <= 1'b0;
			sel_q     <= 1'b0;
			req_q     <= 1'b0;
			stopped_q <= 1'b0;
			rsn_q     <= 8'd0;
			trip_q    <= TRIP_NONE;
			relay_q   <= 3'd0;
			buz_q     <= BUZ_SILENT;
			tis_q     <= '0;
			trun_q    <= '0;
			tss_q     <= '0;
			boot_q    <= '0;
			res_q     <= '0;
		end else if (fire) begin
			mode_q    <= md;
			enable_q  <= en;
			lockout_q <= lo;
			sel_q     <= sel;
			req_q     <= req;
			stopped_q <= hs;
			rsn_q     <= rsn;
			trip_q    <= trip;
			relay_q   <= rel;
			buz_q     <= buz;
			tis_q     <= tis;
			trun_q    <= trun;
			tss_q     <= tss;
			boot_q    <= boot;
			res_q.start_result     <= sres;
			res_q.drive_state      <= md;
			res_q.changeover_relay <= rel[RLY_CO];
			res_q.start_relay      <= rel[RLY_START];
			res_q.stop_relay       <= rel[RLY_STOP];
			res_q.buzzer_mode      <= buz;
			res_q.last_trip        <= trip;
			res_q.event_valid      <= evv;
			res_q.event_on         <= evon;
			res_q.event_reason     <= evr;
			res_q.running_ms       <= (md == ST_RUN) ? CMP_W'(trun) : '0;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ----- rtl/latching_starter_motor_sequencer.sv -----
// Top level of the latching starter motor sequencer.
// Holds the configuration registers, the input register and the handshakes.
// Depends on lsms_pkg and lsms_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event word: a 1 ms tick,
//   start, stop, enable, lockout or clear-fault, plus the current reading and
//   protection verdicts. Output channel (out_valid / out_stall) returns exactly
//   one result word per event: start result, drive state, relays, buzzer,
//   last trip, history event and running time.
//   An accepted word lands in the input register; once the result slot is free
//   or draining, it is evaluated and its result registered, raising out_valid.
//   Throughput: one event per cycle while out_stall is low; the state update
//   is a single combinational pass of timer increments and 32-bit compares
//   between input and result registers.
//   Stall: while the output register holds an untaken result and out_stall is
//   high, the input register holds its word and in_stall rises once it is full.
//   Reset (arst_n low): state idle, enabled, unlocked, well motor selected,
//   relays off, timers zero, registers at their defaults, both channels empty.
//   Configuration (cfg_we, cfg_index, cfg_data) is written by the user only
//   while idle; the block itself does not enforce this.
`default_nettype none

module latching_starter_motor_sequencer #(
	parameter int TIMER_BITS = lsms_pkg::TIMER_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [2:0]                      kind,
	input  wire logic                            motor,
	input  wire logic [7:0]                      reason,
	input  wire logic                            switch_on,
	input  wire logic [15:0]                     amps,
	input  wire logic                            current_armed,
	input  wire logic [3:0]                      start_gate_trip,
	input  wire logic                            routing_valid,
	input  wire logic [3:0]                      prot_trip,
	// Output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [3:0]                           start_result,
	output logic [3:0]                           drive_state,
	output logic                                 changeover_relay,
	output logic                                 start_relay,
	output logic                                 stop_relay,
	output logic [1:0]                           buzzer_mode,
	output logic [3:0]                           last_trip,
	output logic                                 event_valid,
	output logic                                 event_on,
	output logic [7:0]                           event_reason,
	output logic [31:0]                          running_ms,
	// Configuration port
	input  wire logic                            cfg_we,
	input  wire logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsms_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  out_valid_q;
	logic  fire;
	logic  in_take;
	res_t  res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_off_ms    <= MIN_OFF_RST;
			cfg_q.pre_start_ms  <= PRE_START_RST;
			cfg_q.quiet_tmo_ms  <= QUIET_TMO_RST;
			cfg_q.settle_ms     <= SETTLE_RST;
			cfg_q.pulse_ms      <= PULSE_RST;
			cfg_q.amp_low_well  <= AMP_WELL_RST;
			cfg_q.amp_low_bore  <= AMP_BORE_RST;
			cfg_q.boot_grace_ms <= BOOT_GRACE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_OFF:    cfg_q.min_off_ms    <= cfg_data;
				CFG_PRE_START:  cfg_q.pre_start_ms  <= cfg_data;
				CFG_QUIET_TMO:  cfg_q.quiet_tmo_ms  <= cfg_data;
				CFG_SETTLE:     cfg_q.settle_ms     <= cfg_data;
				CFG_PULSE:      cfg_q.pulse_ms      <= cfg_data[15:0];
				CFG_AMP_WELL:   cfg_q.amp_low_well  <= cfg_data[15:0];
				CFG_AMP_BORE:   cfg_q.amp_low_bore  <= cfg_data[15:0];
				CFG_BOOT_GRACE: cfg_q.boot_grace_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input word when the result slot is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Hold handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind            <= kind;
			item_s1.motor           <= motor;
			item_s1.reason          <= reason;
			item_s1.switch_on       <= switch_on;
			item_s1.amps            <= amps;
			item_s1.current_armed   <= current_armed;
			item_s1.start_gate_trip <= start_gate_trip;
			item_s1.routing_valid   <= routing_valid;
			item_s1.prot_trip       <= prot_trip;
		end
	end

	lsms_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid        = out_valid_q;
	assign start_result     = res.start_result;
	assign drive_state      = res.drive_state;
	assign changeover_relay = res.changeover_relay;
	assign start_relay      = res.start_relay;
	assign stop_relay       = res.stop_relay;
	assign buzzer_mode      = res.buzzer_mode;
	assign last_trip        = res.last_trip;
	assign event_valid      = res.event_valid;
	assign event_on         = res.event_on;
	assign event_reason     = res.event_reason;
	assign running_ms       = res.running_ms;

	// Hold a stalled result word unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(drive_state) && $stable(running_ms)))
		else $error("stalled result word changed");

	// Input stalls only behind a held, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// Running time is reported only in the running state
	a_run_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && running_ms != 32'd0) |-> (drive_state == DRV_RUN))
		else $error("running time outside running state");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking bench for latching_starter_motor_sequencer: directed events,
// then random start/run/stop cycles under several register settings, with
// random gaps on both channels. Depends on lsms_pkg and the RTL top only.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lsms_pkg::*;

	// Event kinds the block ignores
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam logic WELL_SEL = 1'b0;
	localparam logic BORE_SEL = 1'b1;
	localparam logic [23:0] REG24_MAX = 24'hFFFFFF;
	localparam logic [15:0] REG16_MAX = 16'hFFFF;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic motor = 1'b0;
	logic [7:0] reason = '0;
	logic switch_on = 1'b0;
	logic [15:0] amps = '0;
	logic current_armed = 1'b0;
	logic [3:0] start_gate_trip = '0;
	logic routing_valid = 1'b0;
	logic [3:0] prot_trip = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] start_result;
	logic [3:0] drive_state;
	logic changeover_relay;
	logic start_relay;
	logic stop_relay;
	logic [1:0] buzzer_mode;
	logic [3:0] last_trip;
	logic event_valid;
	logic event_on;
	logic [7:0] event_reason;
	logic [31:0] running_ms;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	latching_starter_motor_sequencer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .motor(motor), .reason(reason), .switch_on(switch_on),
		.amps(amps), .current_armed(current_armed), .start_gate_trip(start_gate_trip),
		.routing_valid(routing_valid), .prot_trip(prot_trip),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_result(start_result), .drive_state(drive_state),
		.changeover_relay(changeover_relay), .start_relay(start_relay),
		.stop_relay(stop_relay), .buzzer_mode(buzzer_mode), .last_trip(last_trip),
		.event_valid(event_valid), .event_on(event_on), .event_reason(event_reason),
		.running_ms(running_ms),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	item_t pending_events[$];
	res_t expected_status[$];
	item_t word_on_bus = '0;
	int unsigned queued = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	logic quiet_tail = 1'b0;

	// Shadow of the register file
	cfg_t cfg_shadow = '{MIN_OFF_RST, PRE_START_RST, QUIET_TMO_RST, SETTLE_RST,
		PULSE_RST, AMP_WELL_RST, AMP_BORE_RST, BOOT_GRACE_RST};

	// Shadow of the sequencer state
	logic [3:0] m_state = DRV_IDLE;
	logic m_enabled = 1'b1;
	logic m_locked = 1'b0;
	logic m_stopped = 1'b0;
	logic m_sel = WELL_SEL;
	logic m_req = WELL_SEL;
	logic [7:0] m_reason = '0;
	logic [3:0] m_trip = TRIP_NONE;
	logic [31:0] m_t_state = '0;
	logic [31:0] m_t_run = '0;
	logic [31:0] m_t_off = '0;
	logic [31:0] m_boot = '0;
	logic [2:0] m_relays = '0;
	logic [1:0] m_buzz = BUZ_SILENT;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] saturating(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic void enter_state(input logic [3:0] s);
		if (m_state != s) begin
			m_state = s;
			m_t_state = '0;
		end
	endfunction

	function automatic logic motor_turning(input logic [15:0] a);
		return a >= (m_sel ? cfg_shadow.amp_low_bore : cfg_shadow.amp_low_well);
	endfunction

	function automatic void pulse_stop(input logic [7:0] why);
		m_reason = why;
		m_relays[RLY_START] = 1'b0;
		m_relays[RLY_STOP] = 1'b1;
		enter_state(DRV_XPULSE);
	endfunction

	function automatic void note_motor_stopped();
		m_t_off = '0;
		m_stopped = 1'b1;
	endfunction

	// Advance the shadow sequencer by one event and return its status word
	function automatic res_t next_status(input item_t w);
		res_t r;
		logic run_fsm;
		r = '0;
		case (w.kind)
			KIND_TICK: begin
				m_t_state = saturating(m_t_state);
				m_t_run = saturating(m_t_run);
				m_t_off = saturating(m_t_off);
				m_boot = saturating(m_boot);
				run_fsm = m_enabled && (m_boot >= 32'(cfg_shadow.boot_grace_ms));
				if (run_fsm) begin
					case (m_state)
						DRV_WELDED: begin
							if (m_buzz == BUZ_SILENT)
								m_buzz = BUZ_ALARM;
							if (!motor_turning(w.amps)) begin
								m_buzz = BUZ_SILENT;
								note_motor_stopped();
								enter_state(DRV_IDLE);
							end
						end
						DRV_IDLE: begin
							if (motor_turning(w.amps)) begin
								m_t_run = '0;
								enter_state(DRV_RUN);
							end
						end
						DRV_PRE: begin
							if (m_t_state >= 32'(cfg_shadow.pre_start_ms)) begin
								m_buzz = BUZ_SILENT;
								if (w.start_gate_trip != TRIP_NONE) begin
									m_trip = w.start_gate_trip;
									enter_state(DRV_FAULT);
								end else if (m_req == m_sel) begin
									enter_state(DRV_SPULSE);
									m_relays[RLY_START] = 1'b1;
								end else begin
									enter_state(DRV_QUIET);
								end
							end
						end
						DRV_QUIET: begin
							if (!motor_turning(w.amps)) begin
								m_sel = m_req;
								m_relays[RLY_CO] = m_sel;
								enter_state(DRV_CHANGE);
							end else if (m_t_state >= 32'(cfg_shadow.quiet_tmo_ms)) begin
								m_trip = TRIP_STOP_FAILED;
								enter_state(DRV_FAULT);
							end
						end
						DRV_CHANGE: begin
							if (m_t_state >= 32'(cfg_shadow.settle_ms)) begin
								m_relays[RLY_START] = 1'b1;
								enter_state(DRV_SPULSE);
							end
						end
						DRV_SPULSE, DRV_XPULSE: begin
							if (m_t_state >= 32'(cfg_shadow.pulse_ms)) begin
								m_relays[RLY_START] = 1'b0;
								m_relays[RLY_STOP] = 1'b0;
								enter_state((m_state == DRV_SPULSE) ? DRV_SCONF : DRV_XCONF);
							end
						end
						DRV_SCONF: begin
							if (motor_turning(w.amps)) begin
								m_t_run = '0;
								r.event_valid = 1'b1;
								r.event_on = 1'b1;
								r.event_reason = m_reason;
								enter_state(DRV_RUN);
							end else if (w.prot_trip != TRIP_NONE) begin
								m_trip = w.prot_trip;
								enter_state(DRV_FAULT);
							end
						end
						DRV_RUN: begin
							if (!motor_turning(w.amps)) begin
								note_motor_stopped();
								r.event_valid = 1'b1;
								r.event_reason = RSN_POWER_CUT;
								enter_state(DRV_IDLE);
							end else if (w.prot_trip != TRIP_NONE) begin
								m_trip = w.prot_trip;
								pulse_stop(RSN_PROTECTION);
							end
						end
						DRV_XCONF: begin
							if (!motor_turning(w.amps)) begin
								note_motor_stopped();
								r.event_valid = 1'b1;
								r.event_reason = m_reason;
								if (m_locked)
									enter_state(DRV_LOCKED);
								else
									enter_state((m_trip != TRIP_NONE) ? DRV_FAULT : DRV_IDLE);
							end else if (w.prot_trip != TRIP_NONE) begin
								m_trip = w.prot_trip;
								enter_state(DRV_WELDED);
							end
						end
						default: ;
					endcase
				end
			end
			KIND_START: begin
				if (!m_enabled)
					r.start_result = RES_DISABLED;
				else if (m_locked)
					r.start_result = RES_LOCKOUT;
				else if (m_state == DRV_WELDED)
					r.start_result = RES_WELDED;
				else if (m_state == DRV_FAULT)
					r.start_result = RES_FAULT;
				else if (m_state != DRV_IDLE)
					r.start_result = RES_BUSY;
				else if (m_stopped && m_t_off < 32'(cfg_shadow.min_off_ms))
					r.start_result = RES_SHORT;
				else if (!w.current_armed)
					r.start_result = RES_UNCAL;
				else if (w.start_gate_trip != TRIP_NONE) begin
					m_trip = w.start_gate_trip;
					r.start_result = RES_GATE;
				end else if (w.motor == BORE_SEL && !w.routing_valid)
					r.start_result = RES_ROUTING;
				else begin
					m_req = w.motor;
					m_reason = w.reason;
					m_buzz = BUZ_COUNTDOWN;
					enter_state(DRV_PRE);
					r.start_result = RES_ACCEPTED;
				end
			end
			KIND_STOP: begin
				if (m_enabled) begin
					if (m_state == DRV_PRE) begin
						m_buzz = BUZ_SILENT;
						enter_state(DRV_IDLE);
					end else if (m_state == DRV_RUN || m_state == DRV_SCONF
							|| m_state == DRV_SPULSE) begin
						pulse_stop(w.reason);
					end
				end
			end
			KIND_ENABLE: begin
				m_enabled = w.switch_on;
				if (!w.switch_on) begin
					m_relays[RLY_START] = 1'b0;
					m_relays[RLY_STOP] = 1'b0;
					enter_state(DRV_DISABLED);
				end else begin
					enter_state(m_locked ? DRV_LOCKED : DRV_IDLE);
				end
			end
			KIND_LOCKOUT: begin
				m_locked = w.switch_on;
				if (m_enabled) begin
					if (w.switch_on) begin
						if (m_state == DRV_RUN || m_state == DRV_SCONF) begin
							pulse_stop(RSN_LOCKOUT);
						end else if (m_state == DRV_IDLE || m_state == DRV_PRE) begin
							m_buzz = BUZ_SILENT;
							enter_state(DRV_LOCKED);
						end
					end else if (m_state == DRV_LOCKED) begin
						enter_state(DRV_IDLE);
					end
				end
			end
			KIND_CLEAR: begin
				if (m_state == DRV_FAULT) begin
					m_trip = TRIP_NONE;
					enter_state(m_locked ? DRV_LOCKED : DRV_IDLE);
				end
			end
			default: ;
		endcase
		r.drive_state = m_state;
		r.changeover_relay = m_relays[RLY_CO];
		r.start_relay = m_relays[RLY_START];
		r.stop_relay = m_relays[RLY_STOP];
		r.buzzer_mode = m_buzz;
		r.last_trip = m_trip;
		r.running_ms = (m_state == DRV_RUN) ? m_t_run : '0;
		return r;
	endfunction

	// Drive words: hold a stalled word, otherwise offer the next or idle a burst
	always @(posedge clk) begin : drive_events
		item_t nxt;
		if (in_valid && !in_stall)
			expected_status.push_back(next_status(word_on_bus));
		if (!in_valid || !in_stall) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				if (!quiet_tail && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else begin
					nxt = pending_events.pop_front();
					word_on_bus <= nxt;
					kind <= nxt.kind;
					motor <= nxt.motor;
					reason <= nxt.reason;
					switch_on <= nxt.switch_on;
					amps <= nxt.amps;
					current_armed <= nxt.current_armed;
					start_gate_trip <= nxt.start_gate_trip;
					routing_valid <= nxt.routing_valid;
					prot_trip <= nxt.prot_trip;
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Check each taken status word and stall the output in random bursts
	always @(posedge clk) begin : check_status
		res_t want;
		if (out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				report_mismatch("status word with nothing expected");
			end else begin
				want = expected_status.pop_front();
				check_field("start_result", 32'(start_result), 32'(want.start_result));
				check_field("drive_state", 32'(drive_state), 32'(want.drive_state));
				check_field("changeover_relay", 32'(changeover_relay),
					32'(want.changeover_relay));
				check_field("start_relay", 32'(start_relay), 32'(want.start_relay));
				check_field("stop_relay", 32'(stop_relay), 32'(want.stop_relay));
				check_field("buzzer_mode", 32'(buzzer_mode), 32'(want.buzzer_mode));
				check_field("last_trip", 32'(last_trip), 32'(want.last_trip));
				check_field("event_valid", 32'(event_valid), 32'(want.event_valid));
				check_field("event_on", 32'(event_on), 32'(want.event_on));
				check_field("event_reason", 32'(event_reason), 32'(want.event_reason));
				check_field("running_ms", running_ms, want.running_ms);
			end
			results_seen++;
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_OFF: cfg_shadow.min_off_ms = data;
			CFG_PRE_START: cfg_shadow.pre_start_ms = data;
			CFG_QUIET_TMO: cfg_shadow.quiet_tmo_ms = data;
			CFG_SETTLE: cfg_shadow.settle_ms = data;
			CFG_PULSE: cfg_shadow.pulse_ms = data[15:0];
			CFG_AMP_WELL: cfg_shadow.amp_low_well = data[15:0];
			CFG_AMP_BORE: cfg_shadow.amp_low_bore = data[15:0];
			CFG_BOOT_GRACE: cfg_shadow.boot_grace_ms = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [23:0] min_off, pre, quiet, settle,
			input logic [15:0] pulse, well, bore, input logic [23:0] grace);
		write_reg(CFG_MIN_OFF, min_off);
		write_reg(CFG_PRE_START, pre);
		write_reg(CFG_QUIET_TMO, quiet);
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_PULSE, 24'(pulse));
		write_reg(CFG_AMP_WELL, 24'(well));
		write_reg(CFG_AMP_BORE, 24'(bore));
		write_reg(CFG_BOOT_GRACE, grace);
	endtask

	// Hold until every word has been sent and every status word checked
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_status.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic add(input item_t w);
		pending_events.push_back(w);
		queued++;
	endtask

	function automatic item_t make_event(input logic [2:0] k, input logic m,
			input logic [7:0] rsn, input logic sw, input logic [15:0] a, input logic armed,
			input logic [3:0] gate, input logic routing, input logic [3:0] prot);
		return '{k, m, rsn, sw, a, armed, gate, routing, prot};
	endfunction

	function automatic item_t random_event();
		return make_event(3'($urandom_range(0, 7)), 1'($urandom), 8'($urandom),
			1'($urandom), 16'($urandom), 1'($urandom), 4'($urandom_range(0, 14)),
			1'($urandom), 4'($urandom_range(0, 14)));
	endfunction

	function automatic logic [3:0] rare_trip(input int unsigned one_in);
		return ($urandom_range(1, one_in) == 1) ? 4'($urandom_range(1, 14)) : TRIP_NONE;
	endfunction

	// Current below both floors, or zero when a floor is zero
	function automatic logic [15:0] amps_idle();
		logic [15:0] lo;
		lo = (cfg_shadow.amp_low_well < cfg_shadow.amp_low_bore)
			? cfg_shadow.amp_low_well : cfg_shadow.amp_low_bore;
		if (lo == 0)
			return '0;
		return 16'($urandom_range(0, lo - 1));
	endfunction

	// Current at or above both floors
	function automatic logic [15:0] amps_turning();
		logic [15:0] hi;
		hi = (cfg_shadow.amp_low_well > cfg_shadow.amp_low_bore)
			? cfg_shadow.amp_low_well : cfg_shadow.amp_low_bore;
		return 16'($urandom_range(hi, REG16_MAX));
	endfunction

	function automatic int unsigned capped(input logic [23:0] v, input int unsigned lim);
		return (v > lim) ? lim : 32'(v);
	endfunction

	function automatic item_t tick_word(input logic [15:0] a, input logic [3:0] gate,
			input logic [3:0] prot);
		item_t w;
		w = random_event();
		w.kind = KIND_TICK;
		w.amps = a;
		w.start_gate_trip = gate;
		w.prot_trip = prot;
		return w;
	endfunction

	function automatic item_t command_word(input logic [2:0] k, input logic sw);
		item_t w;
		w = random_event();
		w.kind = k;
		w.switch_on = sw;
		return w;
	endfunction

	// Queue one start, run and stop cycle with random detail and rare faults
	task automatic queue_motor_cycle();
		item_t w;
		int unsigned n;
		logic weld;
		// recover from whatever the last cycle left behind
		if ($urandom_range(0, 2) == 0)
			add(command_word(KIND_CLEAR, 1'($urandom)));
		if ($urandom_range(0, 3) == 0)
			add(command_word(KIND_ENABLE, 1'b1));
		if ($urandom_range(0, 3) == 0)
			add(command_word(KIND_LOCKOUT, 1'b0));
		// let the short-cycle guard run out, mostly
		n = capped(cfg_shadow.min_off_ms, 6) + $urandom_range(0, 2);
		repeat (n) add(tick_word(amps_idle(), rare_trip(20), TRIP_NONE));
		w = command_word(KIND_START, 1'($urandom));
		w.current_armed = ($urandom_range(0, 15) != 0);
		w.start_gate_trip = rare_trip(12);
		w.routing_valid = ($urandom_range(0, 9) != 0);
		add(w);
		// warning, changeover and start pulse
		n = capped(cfg_shadow.pre_start_ms, 6) + capped(cfg_shadow.settle_ms, 6)
			+ capped(24'(cfg_shadow.pulse_ms), 6) + $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(0, 24) == 0)
				add(command_word(KIND_STOP, 1'($urandom)));
			add(tick_word(($urandom_range(0, 14) == 0) ? amps_turning() : amps_idle(),
				rare_trip(20), rare_trip(25)));
		end
		// confirm and run
		repeat ($urandom_range(1, 6)) add(tick_word(amps_turning(), rare_trip(8), rare_trip(10)));
		case ($urandom_range(0, 4))
			0, 1: add(command_word(KIND_STOP, 1'($urandom)));
			2: add(command_word(KIND_LOCKOUT, 1'b1));
			3: add(tick_word(amps_idle(), TRIP_NONE, TRIP_NONE));
			default: begin
				add(command_word(KIND_ENABLE, 1'b0));
				add(tick_word(amps_turning(), TRIP_NONE, TRIP_NONE));
				add(command_word(KIND_ENABLE, 1'b1));
			end
		endcase
		// stop pulse and confirm, now and then with a welded contactor
		weld = ($urandom_range(0, 5) == 0);
		n = capped(24'(cfg_shadow.pulse_ms), 6) + $urandom_range(1, 3);
		repeat (n) begin
			if (weld)
				add(tick_word(amps_turning(), TRIP_NONE, 4'($urandom_range(1, 14))));
			else
				add(tick_word(amps_idle(), TRIP_NONE, rare_trip(20)));
		end
		if (weld) begin
			add(command_word(KIND_CLEAR, 1'($urandom)));
			repeat ($urandom_range(1, 3)) add(tick_word(amps_turning(), TRIP_NONE, TRIP_NONE));
			add(tick_word(amps_idle(), TRIP_NONE, TRIP_NONE));
		end
	endtask

	// Fill one phase with mostly whole cycles and some noise, then drain
	task automatic run_phase(input int unsigned n_items);
		int unsigned target;
		@(negedge clk);
		target = queued + n_items;
		while (queued < target) begin
			if ($urandom_range(0, 9) < 7)
				queue_motor_cycle();
			else
				repeat ($urandom_range(1, 4)) add(random_event());
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings, still inside the boot grace
		add(make_event(KIND_TICK, BORE_SEL, 8'hFF, 1'b1, REG16_MAX, 1'b1, 4'd14, 1'b1, 4'd14));
		add(make_event(KIND_SPARE_A, BORE_SEL, 8'h5A, 1'b1, 16'h8001, 1'b1, 4'd1, 1'b0, 4'd1));
		add(make_event(KIND_SPARE_B, WELL_SEL, 8'hA5, 1'b0, 16'h7FFE, 1'b0, 4'd7, 1'b1, 4'd9));
		add(make_event(KIND_START, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b1, 4'd0));
		add(make_event(KIND_START, WELL_SEL, 8'h11, 1'b0, 16'h0000, 1'b1, 4'd14, 1'b1, 4'd0));
		add(make_event(KIND_START, BORE_SEL, 8'h22, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_CLEAR, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_LOCKOUT, WELL_SEL, 8'h00, 1'b1, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_START, WELL_SEL, 8'h33, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b1, 4'd0));
		add(make_event(KIND_LOCKOUT, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_ENABLE, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_START, WELL_SEL, 8'h44, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b1, 4'd0));
		add(make_event(KIND_STOP, WELL_SEL, 8'h55, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_ENABLE, WELL_SEL, 8'h00, 1'b1, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_START, WELL_SEL, 8'hA5, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b1, 4'd0));
		// dropping enable during the warning keeps the buzzer going
		add(make_event(KIND_ENABLE, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_ENABLE, WELL_SEL, 8'h00, 1'b1, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_START, BORE_SEL, 8'hFF, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b1, 4'd0));
		add(make_event(KIND_START, BORE_SEL, 8'h66, 1'b0, 16'h0000, 1'b1, 4'd0, 1'b1, 4'd0));
		add(make_event(KIND_LOCKOUT, WELL_SEL, 8'h00, 1'b1, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_LOCKOUT, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_STOP, WELL_SEL, 8'h77, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		add(make_event(KIND_TICK, WELL_SEL, 8'h00, 1'b0, 16'h0000, 1'b0, 4'd0, 1'b0, 4'd0));
		wait_drained();

		// Short timers, distinct floors per motor
		program_regs(24'd3, 24'd2, 24'd4, 24'd1, 16'd1, 16'd100, 16'd200, 24'd0);
		run_phase(420);
		// Everything zero: current always counts as flowing
		program_regs(24'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0, 24'd0);
		run_phase(160);
		program_regs(24'd5, 24'd3, 24'd6, 24'd2, 16'd2, REG16_MAX, 16'd1000, 24'd20);
		run_phase(330);
		// Largest values: ticks stay inside the boot grace
		program_regs(REG24_MAX, REG24_MAX, REG24_MAX, REG24_MAX, REG16_MAX, REG16_MAX,
			REG16_MAX, REG24_MAX);
		run_phase(60);
		write_reg(CFG_BOOT_GRACE, 24'd0);
		run_phase(120);
		// Random short settings with both channels running flat out
		quiet_tail <= 1'b1;
		program_regs(24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
			24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
			16'($urandom_range(0, 6)), 16'($urandom_range(20, 3000)),
			16'($urandom_range(20, 3000)), 24'($urandom_range(0, 6)));
		run_phase(480);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- latching_starter_motor_sequencer.f -----
rtl/lsms_pkg.sv
rtl/lsms_core.sv
rtl/latching_starter_motor_sequencer.sv
tb/sv/testbench.sv
